// ----- rtl/core/axis_angle_vector_rotate_core_assert.svh -----
// Assertion macros shared by the rotate core.
`ifndef AXIS_ANGLE_VECTOR_ROTATE_CORE_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AAVR_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("aavr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AAVR_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("aavr: next-cycle check failed");

`endif

// ----- rtl/core/aavr_pkg.sv -----
`default_nettype none
package aavr_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned ANGLE_BITS = 16;

  // Q30 one and pi/2 in Q30 scaling
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [30:0] PIH_Q30 = 31'd1686629713;

  // Taylor divisors, highest term first
  localparam int unsigned SIN_STEPS = 6;
  localparam int unsigned COS_STEPS = 7;
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

  // Pipeline depths
  localparam int unsigned AXIS_LAT = 73;
  localparam int unsigned TRIG_LAT = 27;
  localparam int unsigned MAT_LAT  = 7;
  localparam int unsigned TOT_LAT  = AXIS_LAT + MAT_LAT;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  // Round v / 2^k half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned k);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? (64'd0 - unsigned'(v)) : unsigned'(v);
    m   = (mag + (64'd1 << (k - 1))) >> k;
    rnd_shift = v[63] ? -$signed(m) : $signed(m);
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = -32'sh8000_0000;
    end else begin
      sat32 = 32'(v);
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/aavr_if.sv -----
`default_nettype none
interface aavr_in_if import aavr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  a_x;
  logic signed [COORD_W-1:0]  a_y;
  logic signed [COORD_W-1:0]  a_z;
  logic signed [COORD_W-1:0]  b_x;
  logic signed [COORD_W-1:0]  b_y;
  logic signed [COORD_W-1:0]  b_z;
  logic        [ANGLE_W-1:0]  angle_turns;

  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, angle_turns, input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, angle_turns, output ready);
endinterface

interface aavr_out_if import aavr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  rot_x;
  logic signed [COORD_W-1:0]  rot_y;
  logic signed [COORD_W-1:0]  rot_z;
  logic                       degenerate;

  modport source(output valid, rot_x, rot_y, rot_z, degenerate, input ready);
  modport sink(input valid, rot_x, rot_y, rot_z, degenerate, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/aavr_delay.sv -----
`default_nettype none
module aavr_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] line_r [N];

  // Advance the shift line on enable
  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q = line_r[N-1];

endmodule
`default_nettype wire

// ----- rtl/core/aavr_horner.sv -----
`default_nettype none
module aavr_horner import aavr_pkg::*; #(
  parameter int unsigned DIV = 2
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [29:0] x2,
  input  wire logic [30:0] acc,
  output logic      [29:0] x2_q,
  output logic      [30:0] acc_q
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
  localparam logic [38:0] DIV_W = 39'(DIV);

  logic [60:0] prod_r;
  logic [29:0] x2_a_r, x2_b_r, x2_c_r;
  logic [30:0] v_r, est_r, acc_r;
  logic [30:0] v;
  logic [62:0] est_full;
  logic [38:0] rem;
  logic [30:0] quo;

  // Reciprocal estimate, low by at most one
  assign v        = prod_r[60:30];
  assign est_full = 63'(v) * 63'(RECIP);

  // Correct the estimate by one compare
  assign rem = 39'(v_r) - 39'(est_r) * DIV_W;
  assign quo = (rem >= DIV_W) ? est_r + 31'd1 : est_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 61'(x2) * 61'(acc);
      x2_a_r <= x2;
      v_r    <= v;
      est_r  <= est_full[62:32];
      x2_b_r <= x2_a_r;
      acc_r  <= ONE_Q30 - quo;
      x2_c_r <= x2_b_r;
    end
  end

  assign x2_q  = x2_c_r;
  assign acc_q = acc_r;

endmodule
`default_nettype wire

// ----- rtl/core/aavr_trig.sv -----
`default_nettype none
module aavr_trig import aavr_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [ANGLE_W-1:0]        angle,
  output logic signed [COORD_W-1:0]      sin_q,
  output logic signed [COORD_W-1:0]      cos_q
);

  logic [31:0] ph;
  logic [29:0] r;
  logic [29:0] rr_r;
  logic [2:0]  quad_r, quad_d;
  logic [60:0] thp_r;
  logic [60:0] thp_rnd;
  logic [29:0] th_r, th_4_r, th_5_r, th_d;
  logic [59:0] x2p_r;
  logic [29:0] x2_r;
  logic [60:0] sp_r;
  logic [30:0] s0_r, s0_d_r;
  logic [30:0] ss, cc;
  logic signed [31:0] ss_s, cc_s;
  logic signed [31:0] sin_r, cos_r;
  logic signed [31:0] sin_nxt, cos_nxt;

  logic [29:0] sx2 [SIN_STEPS];
  logic [30:0] sacc [SIN_STEPS+1];
  logic [29:0] cx2 [COS_STEPS];
  logic [30:0] cacc [COS_STEPS+1];

  // Fold the phase into the first octant
  assign ph = 32'(angle[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
  assign r  = ph[29:0];
  assign thp_rnd = thp_r + 61'(ONE_Q30 >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rr_r   <= r[29] ? 30'(31'(ONE_Q30) - 31'(r)) : r;
      quad_r <= {ph[31:30], r[29]};
      thp_r  <= 61'(rr_r) * 61'(PIH_Q30);
      th_r   <= thp_rnd[59:30];
      x2p_r  <= 60'(th_r) * 60'(th_r);
      th_4_r <= th_r;
      x2_r   <= x2p_r[59:30];
      th_5_r <= th_4_r;
    end
  end

  // Horner chains for sine and cosine
  assign sx2[0]  = x2_r;
  assign sacc[0] = ONE_Q30;
  assign cx2[0]  = x2_r;
  assign cacc[0] = ONE_Q30;

  for (genvar h = 0; h < SIN_STEPS; h++) begin : g_sin
    if (h == SIN_STEPS - 1) begin : g_last
      aavr_horner #(.DIV(SIN_DIV[h])) u_step (
        .clk(clk), .en(en), .x2(sx2[h]), .acc(sacc[h]), .x2_q(), .acc_q(sacc[h+1])
      );
    end else begin : g_mid
      aavr_horner #(.DIV(SIN_DIV[h])) u_step (
        .clk(clk), .en(en), .x2(sx2[h]), .acc(sacc[h]), .x2_q(sx2[h+1]),
        .acc_q(sacc[h+1])
      );
    end
  end

  for (genvar h = 0; h < COS_STEPS; h++) begin : g_cos
    if (h == COS_STEPS - 1) begin : g_last
      aavr_horner #(.DIV(COS_DIV[h])) u_step (
        .clk(clk), .en(en), .x2(cx2[h]), .acc(cacc[h]), .x2_q(), .acc_q(cacc[h+1])
      );
    end else begin : g_mid
      aavr_horner #(.DIV(COS_DIV[h])) u_step (
        .clk(clk), .en(en), .x2(cx2[h]), .acc(cacc[h]), .x2_q(cx2[h+1]),
        .acc_q(cacc[h+1])
      );
    end
  end

  // Hold the angle until the sine series is done
  aavr_delay #(.W(30), .N(3 * SIN_STEPS)) u_th_dly (
    .clk(clk), .en(en), .d(th_5_r), .q(th_d)
  );

  aavr_delay #(.W(3), .N(TRIG_LAT - 2)) u_quad_dly (
    .clk(clk), .en(en), .d(quad_r), .q(quad_d)
  );

  // Final sine product and alignment with cosine
  always_ff @(posedge clk) begin
    if (en) begin
      sp_r   <= 61'(th_d) * 61'(sacc[SIN_STEPS]);
      s0_r   <= sp_r[60:30];
      s0_d_r <= s0_r;
    end
  end

  // Undo the octant mirror, then apply quadrant signs
  assign ss   = quad_d[0] ? cacc[COS_STEPS] : s0_d_r;
  assign cc   = quad_d[0] ? s0_d_r : cacc[COS_STEPS];
  assign ss_s = $signed({1'b0, ss});
  assign cc_s = $signed({1'b0, cc});

  always_comb begin
    case (quad_t'(quad_d[2:1]))
      QUAD_I:   begin sin_nxt = ss_s;  cos_nxt = cc_s;  end
      QUAD_II:  begin sin_nxt = cc_s;  cos_nxt = -ss_s; end
      QUAD_III: begin sin_nxt = -ss_s; cos_nxt = -cc_s; end
      default:  begin sin_nxt = -cc_s; cos_nxt = ss_s;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule
`default_nettype wire

// ----- rtl/core/aavr_axis.sv -----
`default_nettype none
module aavr_axis import aavr_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [COORD_W-1:0]    a_x,
  input  wire logic signed [COORD_W-1:0]    a_y,
  input  wire logic signed [COORD_W-1:0]    a_z,
  input  wire logic signed [COORD_W-1:0]    b_x,
  input  wire logic signed [COORD_W-1:0]    b_y,
  input  wire logic signed [COORD_W-1:0]    b_z,
  output logic signed [COORD_W-1:0]         n_x,
  output logic signed [COORD_W-1:0]         n_y,
  output logic signed [COORD_W-1:0]         n_z,
  output logic                              degen
);

  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_STEPS = 31;

  logic signed [63:0] p_r  [6];
  logic        [63:0] cr_r [3];
  logic        [63:0] u_r  [3];
  logic        [2:0]  neg_r, neg_d;
  logic        [63:0] orw;
  logic        [3:0]  gnz_nxt, gnz_r;
  logic        [3:0]  gmsb_nxt [4];
  logic        [3:0]  gmsb_r   [4];
  logic        [63:0] u4_r [3];
  logic        [5:0]  p_nxt, psh_r;
  logic               zero_nxt, zero_r, zero_d;
  logic        [63:0] u5_r [3];
  logic        [30:0] v_nxt [3];
  logic        [30:0] v_r  [3];
  logic        [61:0] sq_r [3];
  logic        [30:0] v7_r [3];
  logic        [92:0] v8_r, v_d;
  logic        [63:0] num_r [SQ_STEPS+1];
  logic        [63:0] res_r [SQ_STEPS];
  logic        [31:0] len;
  logic        [31:0] len_r [DIV_STEPS+1];
  logic        [63:0] rem_r [DIV_STEPS+1][3];
  logic        [30:0] quo_r [DIV_STEPS+1][3];
  logic signed [31:0] n_r [3];
  logic               degen_r;

  // Cross-product partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= 64'(a_y) * 64'(b_z);
      p_r[1] <= 64'(b_y) * 64'(a_z);
      p_r[2] <= 64'(b_x) * 64'(a_z);
      p_r[3] <= 64'(a_x) * 64'(b_z);
      p_r[4] <= 64'(a_x) * 64'(b_y);
      p_r[5] <= 64'(b_x) * 64'(a_y);
    end
  end

  // Cross product, wrapping at 64 bits, then magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0] <= unsigned'(p_r[0] - p_r[1]);
      cr_r[1] <= unsigned'(p_r[2] - p_r[3]);
      cr_r[2] <= unsigned'(p_r[4] - p_r[5]);
      for (int k = 0; k < 3; k++) begin
        u_r[k]   <= cr_r[k][63] ? (64'd0 - cr_r[k]) : cr_r[k];
        neg_r[k] <= cr_r[k][63];
      end
    end
  end

  // Leading-one search, first per 16-bit group
  always_comb begin
    orw = u_r[0] | u_r[1] | u_r[2];
    for (int g = 0; g < 4; g++) begin
      gnz_nxt[g]  = |orw[16*g +: 16];
      gmsb_nxt[g] = '0;
      for (int bi = 0; bi < 16; bi++) begin
        if (orw[16*g + bi]) gmsb_nxt[g] = 4'(bi);
      end
    end
  end

  // Then across the groups
  always_comb begin
    p_nxt = '0;
    for (int g = 0; g < 4; g++) begin
      if (gnz_r[g]) p_nxt = {2'(g), gmsb_r[g]};
    end
    zero_nxt = ~|gnz_r;
  end

  // Scale so the largest magnitude has its top bit at bit 30
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (psh_r >= 6'd31) begin
        v_nxt[k] = 31'(u5_r[k] >> (psh_r - 6'd30));
      end else begin
        v_nxt[k] = 31'(u5_r[k] << (6'd30 - psh_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gnz_r  <= gnz_nxt;
      gmsb_r <= gmsb_nxt;
      u4_r   <= u_r;
      psh_r  <= p_nxt;
      zero_r <= zero_nxt;
      u5_r   <= u4_r;
      v_r    <= v_nxt;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= 62'(v_r[k]) * 62'(v_r[k]);
      end
      v7_r     <= v_r;
      num_r[0] <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      v8_r     <= {v7_r[0], v7_r[1], v7_r[2]};
    end
  end

  aavr_delay #(.W(3), .N(AXIS_LAT - 4)) u_neg_dly (
    .clk(clk), .en(en), .d(neg_r), .q(neg_d)
  );

  aavr_delay #(.W(1), .N(AXIS_LAT - 6)) u_zero_dly (
    .clk(clk), .en(en), .d(zero_r), .q(zero_d)
  );

  aavr_delay #(.W(93), .N(SQ_STEPS)) u_v_dly (
    .clk(clk), .en(en), .d(v8_r), .q(v_d)
  );

  // Integer square root, one result bit per stage
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] res_prev;
    logic [63:0] trial;

    if (i == 0) begin : g_first
      assign res_prev = '0;
    end else begin : g_next
      assign res_prev = res_r[i-1];
    end

    assign trial = res_prev + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (num_r[i] >= trial) begin
          num_r[i+1] <= num_r[i] - trial;
          res_r[i]   <= (res_prev >> 1) + BIT;
        end else begin
          num_r[i+1] <= num_r[i];
          res_r[i]   <= res_prev >> 1;
        end
      end
    end
  end

  // Divider setup: numerator with half the divisor added
  assign len = res_r[SQ_STEPS-1][31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0] <= len;
      for (int k = 0; k < 3; k++) begin
        rem_r[0][k] <= (64'(v_d[62 - 31*k +: 31]) << 30) + 64'(len >> 1);
        quo_r[0][k] <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
    localparam int unsigned QB = DIV_STEPS - 1 - t;
    logic [63:0] dsh;

    assign dsh = 64'(len_r[t]) << QB;

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[t+1] <= len_r[t];
        for (int k = 0; k < 3; k++) begin
          if (rem_r[t][k] >= dsh) begin
            rem_r[t+1][k] <= rem_r[t][k] - dsh;
            quo_r[t+1][k] <= quo_r[t][k] | (31'd1 << QB);
          end else begin
            rem_r[t+1][k] <= rem_r[t][k];
            quo_r[t+1][k] <= quo_r[t][k];
          end
        end
      end
    end
  end

  // Restore the component signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= neg_d[k] ? -$signed({1'b0, quo_r[DIV_STEPS][k]})
                           : $signed({1'b0, quo_r[DIV_STEPS][k]});
      end
      degen_r <= zero_d;
    end
  end

  assign n_x   = n_r[0];
  assign n_y   = n_r[1];
  assign n_z   = n_r[2];
  assign degen = degen_r;

endmodule
`default_nettype wire

// ----- rtl/core/aavr_matrix.sv -----
`default_nettype none
module aavr_matrix import aavr_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [COORD_W-1:0]    n_x,
  input  wire logic signed [COORD_W-1:0]    n_y,
  input  wire logic signed [COORD_W-1:0]    n_z,
  input  wire logic signed [COORD_W-1:0]    sin_v,
  input  wire logic signed [COORD_W-1:0]    cos_v,
  input  wire logic signed [COORD_W-1:0]    a_x,
  input  wire logic signed [COORD_W-1:0]    a_y,
  input  wire logic signed [COORD_W-1:0]    a_z,
  input  wire logic                         degen,
  output logic signed [COORD_W-1:0]         rot_x,
  output logic signed [COORD_W-1:0]         rot_y,
  output logic signed [COORD_W-1:0]         rot_z,
  output logic                              degen_q
);

  logic signed [31:0] n [3];
  logic signed [32:0] omc_r, omc2_r;
  logic signed [31:0] c1_r, c2_r, c3_r;
  logic signed [63:0] nn_r [6];
  logic signed [63:0] sn_r [3];
  logic signed [31:0] pr2_r [6];
  logic signed [31:0] ns2_r [3];
  logic signed [31:0] ns3_r [3];
  logic signed [63:0] op_r [6];
  logic signed [63:0] r4 [6];
  logic signed [33:0] m_r [3][3];
  logic signed [63:0] mp_r [3][3];
  logic signed [63:0] acc_r [3];
  logic signed [31:0] rot_r [3];
  logic               degen_r;
  logic [95:0]        a_d;
  logic signed [31:0] av [3];
  logic               degen_d;

  assign n[0] = n_x;
  assign n[1] = n_y;
  assign n[2] = n_z;

  aavr_delay #(.W(96), .N(4)) u_a_dly (
    .clk(clk), .en(en), .d({a_x, a_y, a_z}), .q(a_d)
  );

  aavr_delay #(.W(1), .N(MAT_LAT - 1)) u_dg_dly (
    .clk(clk), .en(en), .d(degen), .q(degen_d)
  );

  assign av[0] = $signed(a_d[95:64]);
  assign av[1] = $signed(a_d[63:32]);
  assign av[2] = $signed(a_d[31:0]);

  // Axis outer products and sine cross terms
  always_ff @(posedge clk) begin
    if (en) begin
      omc_r    <= 33'sd1073741824 - 33'(cos_v);
      c1_r     <= cos_v;
      nn_r[0]  <= 64'(n[0]) * 64'(n[0]);
      nn_r[1]  <= 64'(n[0]) * 64'(n[1]);
      nn_r[2]  <= 64'(n[0]) * 64'(n[2]);
      nn_r[3]  <= 64'(n[1]) * 64'(n[1]);
      nn_r[4]  <= 64'(n[1]) * 64'(n[2]);
      nn_r[5]  <= 64'(n[2]) * 64'(n[2]);
      for (int k = 0; k < 3; k++) begin
        sn_r[k] <= 64'(sin_v) * 64'(n[k]);
      end
    end
  end

  // Round back to Q30
  always_ff @(posedge clk) begin
    if (en) begin
      omc2_r <= omc_r;
      c2_r   <= c1_r;
      for (int k = 0; k < 6; k++) begin
        pr2_r[k] <= 32'(rnd_shift(nn_r[k], 30));
      end
      for (int k = 0; k < 3; k++) begin
        ns2_r[k] <= 32'(rnd_shift(sn_r[k], 30));
      end
    end
  end

  // Scale the outer products by one minus cosine
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        op_r[k] <= 64'(omc2_r) * 64'(pr2_r[k]);
      end
      ns3_r <= ns2_r;
      c3_r  <= c2_r;
    end
  end

  // Assemble the rotation matrix
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      r4[k] = rnd_shift(op_r[k], 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0][0] <= 34'(c3_r) + 34'(r4[0]);
      m_r[0][1] <= 34'(r4[1]) - 34'(ns3_r[2]);
      m_r[0][2] <= 34'(r4[2]) + 34'(ns3_r[1]);
      m_r[1][0] <= 34'(r4[1]) + 34'(ns3_r[2]);
      m_r[1][1] <= 34'(c3_r) + 34'(r4[3]);
      m_r[1][2] <= 34'(r4[4]) - 34'(ns3_r[0]);
      m_r[2][0] <= 34'(r4[2]) - 34'(ns3_r[1]);
      m_r[2][1] <= 34'(r4[4]) + 34'(ns3_r[0]);
      m_r[2][2] <= 34'(c3_r) + 34'(r4[5]);
    end
  end

  // Matrix-vector product, sum and final rounding
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp_r[i][j] <= 64'(m_r[i][j]) * 64'(av[j]);
        end
        acc_r[i] <= rnd_shift(mp_r[i][0], 8) + rnd_shift(mp_r[i][1], 8)
                  + rnd_shift(mp_r[i][2], 8);
        rot_r[i] <= degen_d ? 32'sd0 : sat32(rnd_shift(acc_r[i], 22));
      end
      degen_r <= degen_d;
    end
  end

  assign rot_x   = rot_r[0];
  assign rot_y   = rot_r[1];
  assign rot_z   = rot_r[2];
  assign degen_q = degen_r;

endmodule
`default_nettype wire

// ----- rtl/core/axis_angle_vector_rotate_core.sv -----
// Pipeline: 80 stages plus an output register between input transaction and result valid.
// Throughput: one transaction per cycle while not stalled; the axis path (32-stage square
// root followed by a 31-stage divider) sets the depth, not the rate.
// Stall: all stages hold only when the last stage and output register are full and ready is low.
// Reset: synchronous, active low; clears the valid bits and output valid, not the data.
`default_nettype none
`include "axis_angle_vector_rotate_core_assert.svh"
module axis_angle_vector_rotate_core import aavr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  aavr_in_if.sink       in_chan,
  aavr_out_if.source    out_chan
);

  logic                 en;
  logic                 out_ld;
  logic [TOT_LAT-1:0]   vld_r;
  logic                 out_valid_r;
  logic signed [31:0]   rot_x_q_r, rot_y_q_r, rot_z_q_r;
  logic                 degen_q_r;
  logic [ANGLE_W-1:0]   ang_d;
  logic [95:0]          a_d;
  logic signed [31:0]   n_x, n_y, n_z;
  logic                 ax_degen;
  logic signed [31:0]   sin_v, cos_v;
  logic signed [31:0]   rx, ry, rz;
  logic                 rdeg;

  // Advance unless the last stage is blocked by a full output register
  assign out_ld        = !out_valid_r || out_chan.ready;
  assign en            = !vld_r[TOT_LAT-1] || out_ld;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT_LAT-2:0], in_chan.valid};
    end
  end

  aavr_axis u_axis (
    .clk(clk), .en(en),
    .a_x(in_chan.a_x), .a_y(in_chan.a_y), .a_z(in_chan.a_z),
    .b_x(in_chan.b_x), .b_y(in_chan.b_y), .b_z(in_chan.b_z),
    .n_x(n_x), .n_y(n_y), .n_z(n_z), .degen(ax_degen)
  );

  // Start the angle late so sine and cosine meet the axis
  aavr_delay #(.W(ANGLE_W), .N(AXIS_LAT - TRIG_LAT)) u_ang_dly (
    .clk(clk), .en(en), .d(in_chan.angle_turns), .q(ang_d)
  );

  aavr_trig u_trig (
    .clk(clk), .en(en), .angle(ang_d), .sin_q(sin_v), .cos_q(cos_v)
  );

  aavr_delay #(.W(96), .N(AXIS_LAT)) u_a_dly (
    .clk(clk), .en(en), .d({in_chan.a_x, in_chan.a_y, in_chan.a_z}), .q(a_d)
  );

  aavr_matrix u_matrix (
    .clk(clk), .en(en),
    .n_x(n_x), .n_y(n_y), .n_z(n_z),
    .sin_v(sin_v), .cos_v(cos_v),
    .a_x($signed(a_d[95:64])), .a_y($signed(a_d[63:32])), .a_z($signed(a_d[31:0])),
    .degen(ax_degen),
    .rot_x(rx), .rot_y(ry), .rot_z(rz), .degen_q(rdeg)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= vld_r[TOT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      rot_x_q_r <= rx;
      rot_y_q_r <= ry;
      rot_z_q_r <= rz;
      degen_q_r <= rdeg;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.rot_x      = rot_x_q_r;
  assign out_chan.rot_y      = rot_y_q_r;
  assign out_chan.rot_z      = rot_z_q_r;
  assign out_chan.degenerate = degen_q_r;

  `AAVR_ASSERT_IMP(a_degen_zero, clk, rst_n, out_valid_r && degen_q_r, rot_x_q_r == 32'sd0 && rot_y_q_r == 32'sd0 && rot_z_q_r == 32'sd0)
  `AAVR_ASSERT_IMP(a_full_stall, clk, rst_n, vld_r[TOT_LAT-1] && out_valid_r && !out_chan.ready, !in_chan.ready)
  `AAVR_ASSERT_IMP(a_empty_ready, clk, rst_n, !out_valid_r, in_chan.ready)
  `AAVR_ASSERT_NXT(a_take, clk, rst_n, in_chan.valid && in_chan.ready, vld_r[0])
  `AAVR_ASSERT_NXT(a_freeze, clk, rst_n, !en, $stable(vld_r))

endmodule
`default_nettype wire
